// ----- rtl/core/ipv4_fragment_reassembly_tracker_macros.svh -----
// Assertion macros used by the slot engine of the fragment tracker RTL.
`ifndef IPV4_FRAGMENT_REASSEMBLY_TRACKER_MACROS_SVH
`define IPV4_FRAGMENT_REASSEMBLY_TRACKER_MACROS_SVH
`ifndef ASSERT_OFF
`define IPFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define IPFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define IPFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define IPFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/ipfr_pkg.sv -----
// Types, constants and helpers of the IPv4 fragment tracker.
package ipfr_pkg;
    localparam int SLOTS      = 8;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int MAX_BLOCKS = 8192;
    localparam int WORDS      = (MAX_BLOCKS + 63) / 64;
    localparam int WORD_W     = $clog2(WORDS);
    localparam int CNT_W      = WORD_W + 1;
    localparam int BLK_W      = $clog2(MAX_BLOCKS) + 1;
    localparam int MEM_AW     = SLOT_W + WORD_W;
    localparam int QDEPTH     = 2;

    localparam logic [2:0] ST_MALF   = 3'd0;
    localparam logic [2:0] ST_UNFRAG = 3'd1;
    localparam logic [2:0] ST_HELD   = 3'd2;
    localparam logic [2:0] ST_REASM  = 3'd3;
    localparam logic [2:0] ST_NOSLOT = 3'd4;

    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_SCTP = 8'h84;

    localparam logic [1:0] CLS_UDP   = 2'd0;
    localparam logic [1:0] CLS_TCP   = 2'd1;
    localparam logic [1:0] CLS_SCTP  = 2'd2;
    localparam logic [1:0] CLS_OTHER = 2'd3;

    localparam logic [5:0]  MIN_HDR   = 6'd20;
    localparam logic [3:0]  IP_VER4   = 4'd4;
    localparam logic [16:0] BUF_BYTES = 17'(MAX_BLOCKS * 8);

    typedef enum logic [1:0] {K_MALF, K_UNFRAG, K_FRAG} t_kind;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RESULT} t_bstate;

    typedef struct packed {
        t_kind             kind;
        logic [15:0]       plen;
        logic [15:0]       woff;
        logic [12:0]       frag_offset;
        logic              more_frags;
        logic [1:0]        upper_class;
        logic [63:0]       addrs;
        logic [23:0]       key2;
        logic [BLK_W-1:0]  blk_end;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  slot;
        logic [15:0] write_offset;
        logic [15:0] payload_len;
        logic        copy_header;
        logic [15:0] packet_len;
        logic [1:0]  upper_class;
    } t_result;

    function automatic logic [1:0] class_of(input logic [7:0] proto);
        logic [1:0] c;
        case (proto)
            PROTO_UDP:  c = CLS_UDP;
            PROTO_TCP:  c = CLS_TCP;
            PROTO_SCTP: c = CLS_SCTP;
            default:    c = CLS_OTHER;
        endcase
        return c;
    endfunction
endpackage

// ----- rtl/core/ipv4_fragment_reassembly_tracker.sv -----
// IPv4 fragment tracker: header checks, slot tracking and completion.
//
// Input channel: one beat carries the parsed header fields of one IPv4
// packet (i_in_valid / o_in_ready). Output channel: one beat per packet with
// status, slot, buffer offset, payload length, header-store flag,
// reassembled length and protocol class (o_out_valid / i_out_ready).
// A classifier accepts beats into a two-entry queue; the slot engine drains
// it in order. Malformed, unfragmented and no-slot packets go straight from
// the idle state to the result state. A tracked fragment also passes through
// the scan state: the engine walks all 128 bitmap words of its slot through
// the single read and write port of the bitmap RAM, clearing on allocation,
// marking blocks and checking completion in one pass.
// The result sits in an output register; while the receiver stalls, the
// engine finishes the next packet and the queue keeps accepting until full.
// Reset (synchronous, active low) frees every slot and empties queue and
// output; the bitmap RAM needs no clearing pass since a slot's words are
// rewritten when the slot is allocated.
module ipv4_fragment_reassembly_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_captured_len,
    input  logic [3:0]  i_ip_version,
    input  logic [3:0]  i_header_words,
    input  logic [15:0] i_total_length,
    input  logic [15:0] i_ident,
    input  logic        i_more_frags,
    input  logic [12:0] i_frag_offset,
    input  logic [7:0]  i_protocol,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [2:0]  o_slot,
    output logic [15:0] o_write_offset,
    output logic [15:0] o_payload_len,
    output logic        o_copy_header,
    output logic [15:0] o_packet_len,
    output logic [1:0]  o_upper_class
);
    import ipfr_pkg::*;

    t_item   cls_item, q_item;
    t_result res;
    logic    q_full, q_empty, q_pop;

    assign o_in_ready = !q_full;

    ipfr_front u_front (
        .i_captured_len (i_captured_len),
        .i_ip_version   (i_ip_version),
        .i_header_words (i_header_words),
        .i_total_length (i_total_length),
        .i_ident        (i_ident),
        .i_more_frags   (i_more_frags),
        .i_frag_offset  (i_frag_offset),
        .i_protocol     (i_protocol),
        .i_src_addr     (i_src_addr),
        .i_dst_addr     (i_dst_addr),
        .o_item         (cls_item)
    );

    ipfr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid && !q_full),
        .i_item  (cls_item),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    ipfr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!q_empty),
        .i_item  (q_item),
        .o_pop   (q_pop),
        .o_valid (o_out_valid),
        .o_res   (res),
        .i_ready (i_out_ready)
    );

    assign o_status       = res.status;
    assign o_slot         = res.slot;
    assign o_write_offset = res.write_offset;
    assign o_payload_len  = res.payload_len;
    assign o_copy_header  = res.copy_header;
    assign o_packet_len   = res.packet_len;
    assign o_upper_class  = res.upper_class;
endmodule

// ----- rtl/core/ipfr_front.sv -----
// Front end: header checks and classification of one packet beat.
module ipfr_front (
    input  logic [15:0]     i_captured_len,
    input  logic [3:0]      i_ip_version,
    input  logic [3:0]      i_header_words,
    input  logic [15:0]     i_total_length,
    input  logic [15:0]     i_ident,
    input  logic            i_more_frags,
    input  logic [12:0]     i_frag_offset,
    input  logic [7:0]      i_protocol,
    input  logic [31:0]     i_src_addr,
    input  logic [31:0]     i_dst_addr,
    output ipfr_pkg::t_item o_item
);
    import ipfr_pkg::*;

    logic [5:0]  hlen;
    logic [15:0] plen;
    logic [15:0] woff;
    logic [16:0] span;
    logic [13:0] blocks;
    logic        bad_hdr;

    always_comb begin
        hlen    = {i_header_words, 2'b00};
        bad_hdr = (i_captured_len < 16'(MIN_HDR)) || (hlen < MIN_HDR) ||
                  (i_ip_version != IP_VER4) || (i_total_length < 16'(hlen));
        plen    = i_total_length - 16'(hlen);
        woff    = {i_frag_offset, 3'b000};
        span    = {1'b0, woff} + {1'b0, plen};
        // round payload up to whole 8-byte blocks
        blocks  = 14'(({1'b0, plen} + 17'd7) >> 3);

        o_item.plen        = plen;
        o_item.woff        = woff;
        o_item.frag_offset = i_frag_offset;
        o_item.more_frags  = i_more_frags;
        o_item.upper_class = class_of(i_protocol);
        o_item.addrs       = {i_src_addr, i_dst_addr};
        o_item.key2        = {i_ident, i_protocol};
        o_item.blk_end     = BLK_W'({1'b0, i_frag_offset} + blocks);

        if (bad_hdr) begin
            o_item.kind = K_MALF;
        end else if (!i_more_frags && i_frag_offset == 13'd0) begin
            o_item.kind = K_UNFRAG;
        end else if (span > BUF_BYTES) begin
            o_item.kind = K_MALF;
        end else begin
            o_item.kind = K_FRAG;
        end
    end
endmodule

// ----- rtl/core/ipfr_fifo.sv -----
// Short queue between the classifier and the slot engine.
module ipfr_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ipfr_pkg::t_item i_item,
    input  logic            i_pop,
    output ipfr_pkg::t_item o_item,
    output logic            o_full,
    output logic            o_empty
);
    import ipfr_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    t_item           r_mem [QDEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule

// ----- rtl/core/ipfr_back.sv -----
// Slot engine: key lookup, allocation, bitmap update and completion scan.
module ipfr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ipfr_pkg::t_item   i_item,
    output logic              o_pop,
    output logic              o_valid,
    output ipfr_pkg::t_result o_res,
    input  logic              i_ready
);
    import ipfr_pkg::*;
`include "ipv4_fragment_reassembly_tracker_macros.svh"

    t_bstate            r_state, n_state;
    logic [SLOTS-1:0]   r_busy, n_busy;
    logic [63:0]        r_addr  [SLOTS];
    logic [63:0]        n_addr  [SLOTS];
    logic [23:0]        r_key2  [SLOTS];
    logic [23:0]        n_key2  [SLOTS];
    logic [16:0]        r_final [SLOTS];
    logic [16:0]        n_final [SLOTS];
    logic [63:0]        mem     [1 << MEM_AW];
    logic [63:0]        r_rd_data;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic               r_alloc, n_alloc;
    t_item              r_cur, n_cur;
    logic [BLK_W-1:0]   r_need, n_need;
    logic               r_known, n_known;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_pv, n_pv;
    logic [WORD_W-1:0]  r_pw, n_pw;
    logic               r_ok, n_ok;
    t_result            r_res, n_res;
    t_result            r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic [SLOTS-1:0]   hit;
    logic               hit_any, free_any;
    logic [SLOT_W-1:0]  hit_idx, free_idx, sel;
    logic [16:0]        final_new;
    logic               rd_en, wr_en;
    logic [63:0]        mark, needm, new_word;
    logic [BLK_W-1:0]   bnum;
    logic               ok_now;

    // parallel key match and lowest-index priority picks
    always_comb begin
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            hit[s] = r_busy[s] && r_addr[s] == i_item.addrs && r_key2[s] == i_item.key2;
            if (hit[s]) begin
                hit_any = 1'b1;
                hit_idx = SLOT_W'(s);
            end
            if (!r_busy[s]) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(s);
            end
        end
    end

    // per-bit masks for the bitmap word under update
    always_comb begin
        for (int i = 0; i < 64; i++) begin
            bnum     = BLK_W'({r_pw, 6'(i)});
            mark[i]  = (bnum >= BLK_W'(r_cur.frag_offset)) && (bnum < r_cur.blk_end);
            needm[i] = bnum < r_need;
        end
        new_word = (r_alloc ? 64'd0 : r_rd_data) | mark;
    end

    always_comb begin
        n_state     = r_state;
        n_busy      = r_busy;
        n_addr      = r_addr;
        n_key2      = r_key2;
        n_final     = r_final;
        n_slot      = r_slot;
        n_alloc     = r_alloc;
        n_cur       = r_cur;
        n_need      = r_need;
        n_known     = r_known;
        n_cnt       = r_cnt;
        n_pv        = 1'b0;
        n_pw        = r_pw;
        n_ok        = r_ok;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        o_pop       = 1'b0;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        sel         = hit_any ? hit_idx : free_idx;
        final_new   = '0;
        ok_now      = r_ok;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_pop             = 1'b1;
                    n_cur             = i_item;
                    n_res             = '0;
                    n_res.upper_class = i_item.upper_class;
                    n_res.payload_len = i_item.plen;
                    n_state           = S_RESULT;
                    unique case (i_item.kind)
                        K_MALF: begin
                            n_res = '0;
                        end
                        K_UNFRAG: begin
                            if (hit_any) begin
                                n_busy[hit_idx] = 1'b0;
                            end
                            n_res.status     = ST_UNFRAG;
                            n_res.packet_len = i_item.plen;
                        end
                        K_FRAG: begin
                            n_res.write_offset = i_item.woff;
                            if (!hit_any && !free_any) begin
                                n_res.status = ST_NOSLOT;
                            end else begin
                                if (!hit_any) begin
                                    n_busy[sel] = 1'b1;
                                    n_addr[sel] = i_item.addrs;
                                    n_key2[sel] = i_item.key2;
                                end
                                if (!i_item.more_frags) begin
                                    final_new = {1'b0, i_item.woff} + {1'b0, i_item.plen};
                                end else begin
                                    final_new = hit_any ? r_final[sel] : 17'd0;
                                end
                                n_final[sel]      = final_new;
                                n_need            = BLK_W'(final_new >> 3);
                                n_known           = (final_new != 17'd0);
                                n_slot            = sel;
                                n_alloc           = !hit_any;
                                n_cnt             = '0;
                                n_ok              = 1'b1;
                                n_res.slot        = 3'(sel);
                                n_res.copy_header = (i_item.frag_offset == 13'd0);
                                n_state           = S_SCAN;
                            end
                        end
                        default: begin
                            n_res = '0;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // read word cnt while merging and writing back the previous one
                rd_en = !r_cnt[CNT_W-1];
                if (rd_en) begin
                    n_cnt = r_cnt + 1'b1;
                    n_pv  = 1'b1;
                    n_pw  = r_cnt[WORD_W-1:0];
                end
                if (r_pv) begin
                    wr_en  = 1'b1;
                    ok_now = r_ok && ((new_word & needm) == needm);
                    n_ok   = ok_now;
                    if (r_pw == WORD_W'(WORDS - 1)) begin
                        if (r_known && ok_now) begin
                            n_busy[r_slot]   = 1'b0;
                            n_res.status     = ST_REASM;
                            n_res.packet_len = r_final[r_slot][16] ? 16'hFFFF
                                                                   : r_final[r_slot][15:0];
                        end else begin
                            n_res.status = ST_HELD;
                        end
                        n_state = S_RESULT;
                    end
                end
            end
            S_RESULT: begin
                if (!r_out_valid || i_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= '0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_key2  <= n_key2;
        r_final <= n_final;
        r_slot  <= n_slot;
        r_alloc <= n_alloc;
        r_cur   <= n_cur;
        r_need  <= n_need;
        r_known <= n_known;
        r_cnt   <= n_cnt;
        r_pw    <= n_pw;
        r_ok    <= n_ok;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[{r_slot, r_cnt[WORD_W-1:0]}];
        end
        if (wr_en) begin
            mem[{r_slot, r_pw}] <= new_word;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    `IPFR_ASSERT_IMP(a_scan_slot_busy, i_clk, i_rst_n, r_state == S_SCAN, r_busy[r_slot])
    `IPFR_ASSERT_IMP(a_pend_in_scan, i_clk, i_rst_n, r_pv, r_state == S_SCAN)
    `IPFR_ASSERT_NXT(a_alloc_marks_busy, i_clk, i_rst_n,
        r_state == S_IDLE && i_valid && i_item.kind == K_FRAG && !hit_any && free_any,
        r_busy[r_slot] && r_alloc)
    `IPFR_ASSERT_IMP(a_pop_only_idle, i_clk, i_rst_n, o_pop, r_state == S_IDLE && i_valid)
endmodule
